[hdl/ppi_pkg.sv]
// Shared constants, op codes and the CORDIC arctangent table for the planar
// pose integrator. No dependencies.
`default_nettype none

package ppi_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int ATAN_ENTRIES      = 24;
	// iteration count actually run; the table stops at 24 entries
	localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > ATAN_ENTRIES) ?
		ATAN_ENTRIES : CORDIC_ITERATIONS;
	localparam int ITER_W = $clog2(ATAN_ENTRIES);

	localparam int OP_W    = 2;
	localparam int SPEED_W = 16;
	localparam int RATE_W  = 24;
	localparam int POS_W   = 32;
	localparam int HEAD_W  = 16;
	localparam int DT_W    = 16;

	localparam logic [DT_W-1:0] STEP_TIME_RESET = 16'd655;

	localparam logic [OP_W-1:0] OP_TROT = 2'd0;
	localparam logic [OP_W-1:0] OP_HOLO = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

	// CORDIC datapath widths
	localparam int CV_W = 34;   // x/y vector, Q2.30 with headroom
	localparam int CZ_W = 32;   // angle, 2^-32 turn
	localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

	typedef logic [ITER_W-1:0] iter_t;

	// atan(2^-i) in 2^-32 turn
	function automatic logic signed [CZ_W-1:0] atan_turn(input iter_t i);
		logic signed [CZ_W-1:0] v;
		case (i)
			5'd0:  v = 32'sd536870912;
			5'd1:  v = 32'sd316933406;
			5'd2:  v = 32'sd167458907;
			5'd3:  v = 32'sd85004756;
			5'd4:  v = 32'sd42667331;
			5'd5:  v = 32'sd21354465;
			5'd6:  v = 32'sd10679838;
			5'd7:  v = 32'sd5340245;
			5'd8:  v = 32'sd2670163;
			5'd9:  v = 32'sd1335087;
			5'd10: v = 32'sd667544;
			5'd11: v = 32'sd333772;
			5'd12: v = 32'sd166886;
			5'd13: v = 32'sd83443;
			5'd14: v = 32'sd41722;
			5'd15: v = 32'sd20861;
			5'd16: v = 32'sd10430;
			5'd17: v = 32'sd5215;
			5'd18: v = 32'sd2608;
			5'd19: v = 32'sd1304;
			5'd20: v = 32'sd652;
			5'd21: v = 32'sd326;
			5'd22: v = 32'sd163;
			5'd23: v = 32'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[hdl/ppi_if.sv]
// Valid/ready channel interfaces for the pose integrator: command words in,
// pose words out. Depends on ppi_pkg.
`default_nettype none

interface ppi_in_if
	import ppi_pkg::*;
	;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [SPEED_W-1:0] forward_speed;
	logic signed [SPEED_W-1:0] lateral_speed;
	logic signed [RATE_W-1:0]  turn_rate;
	logic signed [POS_W-1:0]   load_x;
	logic signed [POS_W-1:0]   load_y;
	logic [HEAD_W-1:0]         load_heading;

	modport source (output valid, op, forward_speed, lateral_speed, turn_rate,
		load_x, load_y, load_heading, input ready);
	modport sink (input valid, op, forward_speed, lateral_speed, turn_rate,
		load_x, load_y, load_heading, output ready);
endinterface

interface ppi_out_if
	import ppi_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [HEAD_W-1:0]       heading;

	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

`default_nettype wire

[hdl/planar_pose_integrator_unit.sv]
// Planar pose integrator top level: pose registers, CORDIC sequencer and one
// shared multiplier. Depends on ppi_pkg and the channel interfaces in ppi_if.
`default_nettype none

// Holds a pose (x, y in Q16.16 m, heading as a 16-bit binary angle) and
// advances it by one Euler step per command word: op 0 trotting, op 1
// holonomic, op 2 loads the pose, op 3 just reports it. Every command yields
// one pose word. A step runs the CORDIC loop, one micro-rotation a cycle
// through a single shift-add unit, then a quadrant and rounding state, then
// the products on one shared 36x18 multiplier, then the output load, which
// waits while a stalled pose word sits in the output; load and report go
// straight to it. A new command is taken only when the sequencer is idle;
// a finished pose word may still sit in the output register then. step_time
// is written via cfg_we/cfg_wdata only while the block is idle, a rule for
// the user that the block leaves unenforced, and step_time resets to 655.
module planar_pose_integrator_unit
	import ppi_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [DT_W-1:0] cfg_wdata,
	ppi_in_if.sink               item,
	ppi_out_if.source            result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT  = 3'd1;
	localparam logic [2:0] ST_QUAD = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam int MA_W = 36;
	localparam int MB_W = 18;
	localparam int P_W  = MA_W + MB_W;
	localparam int D_W  = 30;

	logic [2:0]                state_q;
	logic [DT_W-1:0]           dt_q;
	logic signed [POS_W-1:0]   x_q, y_q;
	logic [HEAD_W-1:0]         h_q;

	logic [OP_W-1:0]           op_q;
	logic signed [SPEED_W-1:0] vf_q, vl_q;
	logic signed [RATE_W-1:0]  w_q;

	logic signed [CV_W-1:0]    cx_q, cy_q;
	logic signed [CZ_W-1:0]    cz_q;
	iter_t                     it_q;
	logic [1:0]                quad_q;
	logic signed [MB_W-1:0]    c_q, s_q;

	logic [2:0]                k_q;
	logic signed [P_W-1:0]     prod_q;
	logic signed [MA_W-1:0]    ax_q, ay_q;
	logic signed [D_W-1:0]     dx_q, dy_q;

	logic                      ovalid_q;
	logic signed [POS_W-1:0]   ox_q, oy_q;
	logic [HEAD_W-1:0]         oh_q;

	logic                      accept;
	logic                      out_load;
	logic [HEAD_W-1:0]         h_bias;
	logic [1:0]                quad;
	logic [HEAD_W-1:0]         resid;
	logic signed [CV_W-1:0]    xs, ys, cv, sv, cr, sr;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b, dt_s;
	logic signed [P_W-1:0]     rnd24;
	logic signed [POS_W:0]     x_sum, y_sum;
	logic [31:0]               h_rnd;
	logic signed [POS_W-1:0]   x_sat, y_sat;

	assign accept   = item.valid && item.ready;
	assign out_load = (state_q == ST_FIN) && (!ovalid_q || result.ready);

	assign item.ready     = (state_q == ST_IDLE);
	assign result.valid   = ovalid_q;
	assign result.pos_x   = ox_q;
	assign result.pos_y   = oy_q;
	assign result.heading = oh_q;

	// quadrant reduction of the current heading
	assign h_bias = h_q + 16'h2000;
	assign quad   = h_bias[15:14];
	assign resid  = h_q - {quad, 14'd0};

	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	always_comb begin
		case (quad_q)
			2'd0: begin
				cv = cx_q;
				sv = cy_q;
			end
			2'd1: begin
				cv = -cy_q;
				sv = cx_q;
			end
			2'd2: begin
				cv = -cx_q;
				sv = -cy_q;
			end
			default: begin
				cv = cy_q;
				sv = -cx_q;
			end
		endcase
		cr = (cv + 34'sd8192) >>> 14;
		sr = (sv + 34'sd8192) >>> 14;
	end

	assign dt_s = signed'({2'b00, dt_q});

	// operand select for the shared multiplier
	always_comb begin
		case (k_q)
			3'd0: begin
				mul_a = MA_W'(vf_q);
				mul_b = c_q;
			end
			3'd1: begin
				mul_a = MA_W'(vl_q);
				mul_b = s_q;
			end
			3'd2: begin
				mul_a = MA_W'(vf_q);
				mul_b = s_q;
			end
			3'd3: begin
				mul_a = MA_W'(vl_q);
				mul_b = c_q;
			end
			3'd4: begin
				mul_a = ax_q;
				mul_b = dt_s;
			end
			3'd5: begin
				mul_a = ay_q;
				mul_b = dt_s;
			end
			3'd6: begin
				mul_a = MA_W'(w_q);
				mul_b = dt_s;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Q.40 product to Q16.16, round half up
	assign rnd24 = (prod_q + P_W'(64'sd8388608)) >>> 24;
	assign h_rnd = prod_q[31:0] + 32'd32768;

	assign x_sum = (POS_W+1)'(x_q) + (POS_W+1)'(dx_q);
	assign y_sum = (POS_W+1)'(y_q) + (POS_W+1)'(dy_q);

	always_comb begin
		if (x_sum[POS_W] != x_sum[POS_W-1])
			x_sat = x_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else
			x_sat = x_sum[POS_W-1:0];
		if (y_sum[POS_W] != y_sum[POS_W-1])
			y_sat = y_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else
			y_sat = y_sum[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= STEP_TIME_RESET;
		end else if (cfg_we) begin
			dt_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			x_q      <= '0;
			y_q      <= '0;
			h_q      <= '0;
			it_q     <= '0;
			k_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load)
				ovalid_q <= 1'b1;
			else if (result.valid && result.ready)
				ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						it_q <= '0;
						k_q  <= '0;
						if (item.op == OP_TROT || item.op == OP_HOLO) begin
							state_q <= ST_ROT;
						end else begin
							if (item.op == OP_LOAD) begin
								x_q <= item.load_x;
								y_q <= item.load_y;
								h_q <= item.load_heading;
							end
							state_q <= ST_FIN;
						end
					end
				end
				ST_ROT: begin
					it_q <= it_q + 1'b1;
					if (it_q == ITER_W'(CORDIC_STEPS - 1))
						state_q <= ST_QUAD;
				end
				ST_QUAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					k_q <= k_q + 1'b1;
					if (k_q == 3'd6)
						x_q <= x_sat;
					if (k_q == 3'd7) begin
						y_q <= y_sat;
						if (op_q == OP_TROT)
							h_q <= h_q + h_rnd[31:16];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= item.op;
			vf_q   <= item.forward_speed;
			vl_q   <= item.lateral_speed;
			w_q    <= item.turn_rate;
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= {resid, 16'd0};
			quad_q <= quad;
		end
		if (state_q == ST_ROT) begin
			if (!cz_q[CZ_W-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_turn(it_q);
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_turn(it_q);
			end
		end
		if (state_q == ST_QUAD) begin
			c_q <= cr[MB_W-1:0];
			s_q <= sr[MB_W-1:0];
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			case (k_q)
				3'd1: ax_q <= prod_q[MA_W-1:0];
				3'd2: if (op_q == OP_HOLO) ax_q <= ax_q - prod_q[MA_W-1:0];
				3'd3: ay_q <= prod_q[MA_W-1:0];
				3'd4: if (op_q == OP_HOLO) ay_q <= ay_q + prod_q[MA_W-1:0];
				3'd5: dx_q <= rnd24[D_W-1:0];
				3'd6: dy_q <= rnd24[D_W-1:0];
				default: ;
			endcase
		end
		if (out_load) begin
			ox_q <= x_q;
			oy_q <= y_q;
			oh_q <= h_q;
		end
	end

endmodule

`default_nettype wire

[hdl/ppi_chk.sv]
// Port-level assertions for planar_pose_integrator_unit and the bind that
// attaches them. Depends on ppi_pkg and the top level.
`default_nettype none

module ppi_chk
	import ppi_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic [OP_W-1:0]         in_op,
	input wire logic signed [POS_W-1:0] in_load_x,
	input wire logic [HEAD_W-1:0]       in_load_heading,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [POS_W-1:0] out_pos_x,
	input wire logic [HEAD_W-1:0]       out_heading
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// one command word in flight at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ppi: ready high right after accept");

	// a load into an empty output shows up once ST_FIN has loaded the output register
	a_load_pose: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_op == OP_LOAD && !out_valid) |-> ##2
		(out_valid && out_pos_x == $past(in_load_x, 2) &&
		out_heading == $past(in_load_heading, 2)))
		else $error("ppi: load pose not reported");

	// a step result does not show up as early as a load result does
	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_op == OP_TROT || in_op == OP_HOLO) && !out_valid) |=>
		##1 !out_valid)
		else $error("ppi: step result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_pos_x) &&
		$stable(out_heading)))
		else $error("ppi: stalled pose word changed");

endmodule

bind planar_pose_integrator_unit ppi_chk u_ppi_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (item.valid),
	.in_ready        (item.ready),
	.in_op           (item.op),
	.in_load_x       (item.load_x),
	.in_load_heading (item.load_heading),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.out_pos_x       (result.pos_x),
	.out_heading     (result.heading)
);

`default_nettype wire
